// File: sv/ast_pkg.sv
`timescale 1ns / 1ps
package ast_pkg;

  // Token length cap; the length field is 7 bits wide.
  localparam int MAX_TOKEN_LEN = 127;
  localparam int LenCapInt     = (MAX_TOKEN_LEN < 127) ? MAX_TOKEN_LEN : 127;
  localparam logic [6:0] LEN_CAP = 7'(LenCapInt);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    CLS_SYMBOL    = 4'd0,
    CLS_DECIMAL   = 4'd1,
    CLS_DIRECTIVE = 4'd2,
    CLS_COMMA     = 4'd3,
    CLS_ZERO      = 4'd4,
    CLS_HEX       = 4'd5,
    CLS_OCTAL     = 4'd6,
    CLS_DOLLAR    = 4'd7,
    CLS_REGISTER  = 4'd8,
    CLS_COLON     = 4'd9,
    CLS_LPAREN    = 4'd10,
    CLS_RPAREN    = 4'd11,
    CLS_ERROR     = 4'd12,
    CLS_STRING    = 4'd13,
    CLS_MINUS     = 4'd14
  } tok_class_t;

  typedef enum logic [3:0] {
    M_IDLE      = 4'd0,
    M_SYMBOL    = 4'd1,
    M_DECIMAL   = 4'd2,
    M_DIRECTIVE = 4'd3,
    M_ZERO      = 4'd4,
    M_HEX       = 4'd5,
    M_OCTAL     = 4'd6,
    M_DOLLAR    = 4'd7,
    M_REGISTER  = 4'd8,
    M_DOT       = 4'd9,
    M_ERROR     = 4'd10,
    M_STRING    = 4'd11
  } mode_t;

  // Character properties decided by the front end.
  typedef struct packed {
    logic       gap;
    logic       nul;
    logic       digit;
    logic       octal;
    logic       alpha;
    logic       hex_letter;
    logic       underscore;
    logic       zero;
    logic       x_letter;
    logic       dot;
    logic       dollar;
    logic       quote;
    logic       single;
    tok_class_t single_class;
  } char_info_t;

  typedef struct packed {
    logic [7:0]  char_in;
    logic [15:0] line_number;
    char_info_t  info;
  } ast_item_t;

endpackage

// File: sv/ast_if.sv
`timescale 1ns / 1ps
interface ast_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  char_in;
  logic [15:0] line_number;

  modport source(output valid, output char_in, output line_number, input ready);
  modport sink(input valid, input char_in, input line_number, output ready);
endinterface

interface ast_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  char_out;
  logic        char_kept;
  logic        token_done;
  logic [3:0]  token_class;
  logic [6:0]  token_length;
  logic [15:0] line_out;

  modport source(output valid, output char_out, output char_kept, output token_done,
                 output token_class, output token_length, output line_out, input ready);
  modport sink(input valid, input char_out, input char_kept, input token_done,
               input token_class, input token_length, input line_out, output ready);
endinterface

// File: sv/ast_front.sv
`timescale 1ns / 1ps
module ast_front
  import ast_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  ast_in_if.sink    in_ch,
  output logic      item_valid,
  output ast_item_t item,
  input  logic      item_ready
);

  char_info_t info;
  logic [7:0] c;

  assign c = in_ch.char_in;

  always_comb begin
    info.nul        = (c == 8'd0);
    info.gap        = (c == 8'd0) || (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    info.digit      = (c >= "0" && c <= "9");
    info.octal      = (c >= "0" && c <= "7");
    info.alpha      = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    info.hex_letter = (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    info.underscore = (c == "_");
    info.zero       = (c == "0");
    info.x_letter   = (c == "x") || (c == "X");
    info.dot        = (c == ".");
    info.dollar     = (c == "$");
    info.quote      = (c == "\"");
    info.single     = 1'b1;
    case (c)
      "(":     info.single_class = CLS_LPAREN;
      ")":     info.single_class = CLS_RPAREN;
      ":":     info.single_class = CLS_COLON;
      ",":     info.single_class = CLS_COMMA;
      "-":     info.single_class = CLS_MINUS;
      default: begin
        info.single       = 1'b0;
        info.single_class = CLS_SYMBOL;
      end
    endcase
  end

  // One register stage; refill in the same cycle it drains.
  assign in_ch.ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item.char_in     <= in_ch.char_in;
      item.line_number <= in_ch.line_number;
      item.info        <= info;
    end
  end

endmodule

// File: sv/ast_queue.sv
`timescale 1ns / 1ps
module ast_queue
  import ast_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_valid,
  input  ast_item_t wr_item,
  output logic      wr_ready,
  output logic      rd_valid,
  output ast_item_t rd_item,
  input  logic      rd_ready
);

  ast_item_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push;
  logic               pop;

  assign wr_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_item;
    end
  end

endmodule

// File: sv/ast_back.sv
`timescale 1ns / 1ps
module ast_back
  import ast_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  ast_item_t item,
  output logic      item_ready,
  ast_out_if.source out_ch
);

  mode_t      mode;
  mode_t      mode_next;
  logic [6:0] kept_count;
  logic [6:0] kept_count_next;
  logic [6:0] len_sum;
  logic       keep;
  logic       done;
  tok_class_t cls;
  logic       step;
  char_info_t ci;

  assign ci         = item.info;
  assign item_ready = !out_ch.valid || out_ch.ready;
  assign step       = item_valid && item_ready;

  // Next mode.
  always_comb begin
    mode_next = mode;
    case (mode)
      M_IDLE: begin
        if (ci.gap || ci.single) begin
          mode_next = M_IDLE;
        end else if (ci.zero) begin
          mode_next = M_ZERO;
        end else if (ci.digit) begin
          mode_next = M_DECIMAL;
        end else if (ci.alpha || ci.underscore) begin
          mode_next = M_SYMBOL;
        end else if (ci.dot) begin
          mode_next = M_DOT;
        end else if (ci.dollar) begin
          mode_next = M_DOLLAR;
        end else if (ci.quote) begin
          mode_next = M_STRING;
        end else begin
          mode_next = M_ERROR;
        end
      end
      M_STRING: begin
        if (ci.quote || ci.nul) begin
          mode_next = M_IDLE;
        end
      end
      default: begin
        if (ci.gap) begin
          mode_next = M_IDLE;
        end else begin
          mode_next = M_ERROR;
          case (mode)
            M_SYMBOL:    if (ci.alpha || ci.digit || ci.underscore) mode_next = M_SYMBOL;
            M_DECIMAL:   if (ci.digit) mode_next = M_DECIMAL;
            M_DIRECTIVE: if (ci.alpha || ci.digit) mode_next = M_DIRECTIVE;
            M_HEX:       if (ci.digit || ci.hex_letter) mode_next = M_HEX;
            M_OCTAL:     if (ci.octal) mode_next = M_OCTAL;
            M_REGISTER:  if (ci.alpha || ci.digit) mode_next = M_REGISTER;
            M_ZERO: begin
              if (ci.x_letter) begin
                mode_next = M_HEX;
              end else if (ci.octal) begin
                mode_next = M_OCTAL;
              end else if (ci.alpha || ci.underscore) begin
                mode_next = M_SYMBOL;
              end
            end
            M_DOLLAR:    if (ci.alpha || ci.digit) mode_next = M_REGISTER;
            M_DOT:       if (ci.alpha) mode_next = M_DIRECTIVE;
            default:     mode_next = M_ERROR;
          endcase
        end
      end
    endcase
  end

  // Per-character outputs.
  always_comb begin
    keep = 1'b0;
    done = 1'b0;
    cls  = CLS_SYMBOL;
    case (mode)
      M_IDLE: begin
        keep = !ci.gap && !ci.quote;
        done = ci.single;
        cls  = ci.single ? ci.single_class : CLS_SYMBOL;
      end
      M_STRING: begin
        if (ci.quote) begin
          done = 1'b1;
          cls  = CLS_STRING;
        end else if (ci.nul) begin
          done = 1'b1;
          cls  = CLS_ERROR;
        end else begin
          keep = 1'b1;
        end
      end
      default: begin
        if (ci.gap) begin
          done = 1'b1;
          case (mode)
            M_SYMBOL:    cls = CLS_SYMBOL;
            M_DECIMAL:   cls = CLS_DECIMAL;
            M_DIRECTIVE: cls = CLS_DIRECTIVE;
            M_ZERO:      cls = CLS_ZERO;
            M_HEX:       cls = CLS_HEX;
            M_OCTAL:     cls = CLS_OCTAL;
            M_DOLLAR:    cls = CLS_DOLLAR;
            M_REGISTER:  cls = CLS_REGISTER;
            default:     cls = CLS_ERROR;
          endcase
        end else begin
          keep = 1'b1;
        end
      end
    endcase
  end

  // Saturating kept-character count; cleared when a token ends.
  assign len_sum = (keep && kept_count < LEN_CAP) ? kept_count + 7'd1 : kept_count;
  assign kept_count_next = done ? 7'd0 : len_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      kept_count   <= 7'd0;
      out_ch.valid <= 1'b0;
    end else begin
      if (step) begin
        mode       <= mode_next;
        kept_count <= kept_count_next;
      end
      if (item_ready) begin
        out_ch.valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_ch.char_out     <= item.char_in;
      out_ch.char_kept    <= keep;
      out_ch.token_done   <= done;
      out_ch.token_class  <= done ? cls : CLS_SYMBOL;
      out_ch.token_length <= done ? len_sum : 7'd0;
      out_ch.line_out     <= done ? item.line_number : 16'd0;
    end
  end

endmodule

// File: sv/assembly_source_tokenizer.sv
`timescale 1ns / 1ps
// Assembly source tokenizer: takes one character of a source line per
// transaction on in_ch (a zero character ends the line) and returns exactly
// one result per character on out_ch, in order: the character echoed, whether
// it belongs to the current token text, and, when a token ends on it, the
// token class, its saturating length and the line number. The block sustains
// one character per clock while out_ch does not stall: the back end's lexer
// mode and kept-count registers update once for each accepted character. A
// character's result passes in order through the front register, the
// two-entry queue and the output register on its way to out_ch; either
// side may stall without the other losing data.
module assembly_source_tokenizer
  import ast_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  ast_in_if.sink    in_ch,
  ast_out_if.source out_ch
);

  logic      f_valid;
  logic      f_ready;
  ast_item_t f_item;
  logic      q_valid;
  logic      q_ready;
  ast_item_t q_item;

  ast_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .item_valid (f_valid),
    .item       (f_item),
    .item_ready (f_ready)
  );

  ast_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_item  (f_item),
    .wr_ready (f_ready),
    .rd_valid (q_valid),
    .rd_item  (q_item),
    .rd_ready (q_ready)
  );

  ast_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item       (q_item),
    .item_ready (q_ready),
    .out_ch     (out_ch)
  );

endmodule
